// ===== src/hwd_pkg.sv =====
// Shared types, constants and helpers for the Huffman tree-walk decoder.
package hwd_pkg;

    // Node table geometry
    localparam int MAX_NODES = 512;
    localparam int NODE_AW   = $clog2(MAX_NODES);

    // Field widths
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int CNT_W      = 32;
    localparam int OPCODE_W   = 2;
    localparam int BYTE_BITS  = 8;
    localparam int BIT_CNT_W  = $clog2(BYTE_BITS + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Item opcodes; the unused code does nothing
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_DECODE = 2'd2
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_SYMBOLS = 1'b0,
        CFG_ROOT_INDEX    = 1'b1
    } cfg_reg_t;

    // One node table entry
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_leaf;
        logic [IDX_W-1:0] right_child;
        logic [IDX_W-1:0] left_child;
    } node_entry_t;

    // Symbol handed to the output stage
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             run_last;
        logic             stream_end;
    } push_t;

    // Walk sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // True when an index falls inside the node table
    function automatic logic idx_in_table(logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(MAX_NODES);
    endfunction

    // Table address of a node index
    function automatic logic [NODE_AW-1:0] idx_to_addr(logic [IDX_W-1:0] idx);
        return NODE_AW'(idx);
    endfunction

endpackage

// ===== src/huffman_tree_walk_decoder.sv =====
// Top level of the Huffman tree-walk decoder: config registers, node table, walker, output.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------------------
//  s_       | s_valid / s_ready  | opcode, node_index, left/right_child, node_is_leaf, ...
//  m_       | m_valid / m_ready  | symbol, run_last, stream_end
//  cfg_     | cfg_wr_en          | cfg_addr (register index), cfg_wdata
//
// A decode item reads the root node in the accept cycle, then the current node, then takes
// one tree step per bit through the single node table read port, a leaf check on the node
// the last bit reaches and a closing step; it ends early when the count runs out mid-byte
// and waits whenever a symbol waits on m_ready.
// Each symbol is held back until the next leaf so run_last can be set on the byte's last one.
// Reset (synchronous, active low) clears the walk state and holds s_ready low; the node
// table is not cleared.
module huffman_tree_walk_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [hwd_pkg::OPCODE_W-1:0]      s_opcode,
    input  logic [hwd_pkg::IDX_W-1:0]         s_node_index,
    input  logic [hwd_pkg::IDX_W-1:0]         s_left_child,
    input  logic [hwd_pkg::IDX_W-1:0]         s_right_child,
    input  logic                              s_node_is_leaf,
    input  logic [hwd_pkg::SYM_W-1:0]         s_node_symbol,
    input  logic [hwd_pkg::BYTE_BITS-1:0]     s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hwd_pkg::SYM_W-1:0]         m_symbol,
    output logic                              m_run_last,
    output logic                              m_stream_end,
    input  logic                              cfg_wr_en,
    input  logic [hwd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [hwd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [hwd_pkg::CNT_W-1:0]   total_symbols_reg;
    logic [hwd_pkg::IDX_W-1:0]   root_index_reg;

    logic                        tbl_wr_en;
    logic [hwd_pkg::NODE_AW-1:0] tbl_wr_addr;
    hwd_pkg::node_entry_t        tbl_wr_data;
    logic [hwd_pkg::NODE_AW-1:0] tbl_rd_addr;
    hwd_pkg::node_entry_t        tbl_rd_data;
    hwd_pkg::push_t              push;
    logic                        out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_symbols_reg <= '0;
            root_index_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (hwd_pkg::cfg_reg_t'(cfg_addr))
                hwd_pkg::CFG_TOTAL_SYMBOLS: total_symbols_reg <= cfg_wdata[hwd_pkg::CNT_W-1:0];
                hwd_pkg::CFG_ROOT_INDEX:    root_index_reg    <= cfg_wdata[hwd_pkg::IDX_W-1:0];
            endcase
        end
    end

    // Node table
    hwd_ram #(
        .DATA_W ($bits(hwd_pkg::node_entry_t)),
        .DEPTH  (hwd_pkg::MAX_NODES)
    ) u_node_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    hwd_walker u_walker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_node_index   (s_node_index),
        .s_left_child   (s_left_child),
        .s_right_child  (s_right_child),
        .s_node_is_leaf (s_node_is_leaf),
        .s_node_symbol  (s_node_symbol),
        .s_data_byte    (s_data_byte),
        .total_symbols  (total_symbols_reg),
        .root_index     (root_index_reg),
        .tbl_wr_en      (tbl_wr_en),
        .tbl_wr_addr    (tbl_wr_addr),
        .tbl_wr_data    (tbl_wr_data),
        .tbl_rd_addr    (tbl_rd_addr),
        .tbl_rd_data    (tbl_rd_data),
        .push           (push),
        .out_free       (out_free)
    );

    hwd_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_symbol     (m_symbol),
        .m_run_last   (m_run_last),
        .m_stream_end (m_stream_end)
    );

endmodule

// ===== src/hwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hwd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/hwd_out_stage.sv =====
// Output register for decoded symbols, decoupling the walk from the consumer.
module hwd_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hwd_pkg::push_t            push,
    output logic                      out_free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [hwd_pkg::SYM_W-1:0] m_symbol,
    output logic                      m_run_last,
    output logic                      m_stream_end
);

    logic                      valid_reg;
    logic [hwd_pkg::SYM_W-1:0] symbol_reg;
    logic                      run_last_reg;
    logic                      stream_end_reg;

    // Register can take a new item when empty or being drained
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push.valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            symbol_reg     <= push.symbol;
            run_last_reg   <= push.run_last;
            stream_end_reg <= push.stream_end;
        end
    end

    assign m_valid      = valid_reg;
    assign m_symbol     = symbol_reg;
    assign m_run_last   = run_last_reg;
    assign m_stream_end = stream_end_reg;

endmodule

// ===== src/hwd_walker.sv =====
// Item sequencer and tree walk over the node table, one step per cycle unless the output stalls it.
module hwd_walker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hwd_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic [hwd_pkg::IDX_W-1:0]      s_node_index,
    input  logic [hwd_pkg::IDX_W-1:0]      s_left_child,
    input  logic [hwd_pkg::IDX_W-1:0]      s_right_child,
    input  logic                           s_node_is_leaf,
    input  logic [hwd_pkg::SYM_W-1:0]      s_node_symbol,
    input  logic [hwd_pkg::BYTE_BITS-1:0]  s_data_byte,
    // configuration
    input  logic [hwd_pkg::CNT_W-1:0]      total_symbols,
    input  logic [hwd_pkg::IDX_W-1:0]      root_index,
    // node table
    output logic                           tbl_wr_en,
    output logic [hwd_pkg::NODE_AW-1:0]    tbl_wr_addr,
    output hwd_pkg::node_entry_t           tbl_wr_data,
    output logic [hwd_pkg::NODE_AW-1:0]    tbl_rd_addr,
    input  hwd_pkg::node_entry_t           tbl_rd_data,
    // output stage
    output hwd_pkg::push_t                 push,
    input  logic                           out_free
);

    hwd_pkg::state_t state_reg, state_next;

    logic [hwd_pkg::IDX_W-1:0]     walk_node_reg, walk_node_next;
    logic [hwd_pkg::CNT_W-1:0]     symbols_left_reg, symbols_left_next;
    logic                          active_reg, active_next;
    logic [hwd_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [hwd_pkg::SYM_W-1:0]     pend_sym_reg, pend_sym_next;
    logic                          pend_end_reg, pend_end_next;
    logic [hwd_pkg::BYTE_BITS-1:0] byte_reg, byte_next;
    hwd_pkg::node_entry_t          root_entry_reg, root_entry_next;
    logic [hwd_pkg::IDX_W-1:0]     last_idx_reg;
    logic                          oor_reg;

    logic                      accept;
    hwd_pkg::opcode_t          op;
    hwd_pkg::node_entry_t      cur_entry;
    hwd_pkg::node_entry_t      base_entry;
    logic                      leaf_hit;
    logic                      last_sym;
    logic                      stall;
    logic                      byte_done;
    logic                      dir_bit;
    logic [hwd_pkg::IDX_W-1:0] next_idx;
    logic [hwd_pkg::IDX_W-1:0] rd_idx;

    assign accept = s_valid && s_ready;
    assign op     = hwd_pkg::opcode_t'(s_opcode);

    // Entry just read; indexes past the table read as zero
    assign cur_entry = oor_reg ? '0 : tbl_rd_data;

    // One tree step: the node reached is checked, except the one the byte starts on
    assign leaf_hit   = (bit_cnt_reg != '0) && cur_entry.is_leaf;
    assign base_entry = leaf_hit ? root_entry_reg : cur_entry;
    assign dir_bit    = byte_reg[bit_cnt_reg[$clog2(hwd_pkg::BYTE_BITS)-1:0]];
    assign next_idx   = dir_bit ? base_entry.right_child : base_entry.left_child;
    assign last_sym   = leaf_hit && (symbols_left_reg == hwd_pkg::CNT_W'(1));
    assign stall      = leaf_hit && pend_valid_reg && !out_free;
    assign byte_done  = (bit_cnt_reg == hwd_pkg::BIT_CNT_W'(hwd_pkg::BYTE_BITS)) || last_sym;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hwd_pkg::ST_IDLE: begin
                if (accept && op == hwd_pkg::OP_DECODE && active_reg) begin
                    state_next = hwd_pkg::ST_ROOT;
                end
            end
            hwd_pkg::ST_ROOT: begin
                state_next = hwd_pkg::ST_WALK;
            end
            hwd_pkg::ST_WALK: begin
                if (!stall && byte_done) begin
                    state_next = hwd_pkg::ST_FLUSH;
                end
            end
            hwd_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = hwd_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Outputs: handshake, table port, symbol push
    always_comb begin
        s_ready     = 1'b0;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = hwd_pkg::idx_to_addr(s_node_index);
        tbl_wr_data = '{symbol:      s_node_symbol,
                        is_leaf:     s_node_is_leaf,
                        right_child: s_right_child,
                        left_child:  s_left_child};
        rd_idx      = last_idx_reg;
        push        = '0;
        unique case (state_reg)
            hwd_pkg::ST_IDLE: begin
                // no item is taken while reset is held
                s_ready   = aresetn;
                tbl_wr_en = accept && op == hwd_pkg::OP_LOAD
                            && hwd_pkg::idx_in_table(s_node_index);
                rd_idx    = root_index;
            end
            hwd_pkg::ST_ROOT: begin
                rd_idx = walk_node_reg;
            end
            hwd_pkg::ST_WALK: begin
                if (!stall && !byte_done) begin
                    rd_idx = next_idx;
                end
                // A new leaf releases the one held back, which is then not last
                if (!stall && leaf_hit && pend_valid_reg) begin
                    push = '{valid: 1'b1, symbol: pend_sym_reg,
                             run_last: 1'b0, stream_end: pend_end_reg};
                end
            end
            hwd_pkg::ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    push = '{valid: 1'b1, symbol: pend_sym_reg,
                             run_last: 1'b1, stream_end: pend_end_reg};
                end
            end
        endcase
    end

    assign tbl_rd_addr = hwd_pkg::idx_to_addr(rd_idx);

    // Datapath next values
    always_comb begin
        walk_node_next    = walk_node_reg;
        symbols_left_next = symbols_left_reg;
        active_next       = active_reg;
        bit_cnt_next      = bit_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_sym_next     = pend_sym_reg;
        pend_end_next     = pend_end_reg;
        byte_next         = byte_reg;
        root_entry_next   = root_entry_reg;
        unique case (state_reg)
            hwd_pkg::ST_IDLE: begin
                if (accept) begin
                    priority case (op)
                        hwd_pkg::OP_START: begin
                            symbols_left_next = total_symbols;
                            walk_node_next    = root_index;
                            active_next       = (total_symbols != '0);
                        end
                        hwd_pkg::OP_DECODE: begin
                            byte_next    = s_data_byte;
                            bit_cnt_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            hwd_pkg::ST_ROOT: begin
                root_entry_next = cur_entry;
            end
            hwd_pkg::ST_WALK: begin
                if (!stall) begin
                    if (leaf_hit) begin
                        pend_valid_next   = 1'b1;
                        pend_sym_next     = cur_entry.symbol;
                        pend_end_next     = last_sym;
                        symbols_left_next = symbols_left_reg - hwd_pkg::CNT_W'(1);
                        if (last_sym) begin
                            active_next = 1'b0;
                        end
                    end
                    if (byte_done) begin
                        if (leaf_hit) begin
                            walk_node_next = root_index;
                        end
                    end else begin
                        walk_node_next = next_idx;
                        bit_cnt_next   = bit_cnt_reg + hwd_pkg::BIT_CNT_W'(1);
                    end
                end
            end
            hwd_pkg::ST_FLUSH: begin
                if (out_free) begin
                    pend_valid_next = 1'b0;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= hwd_pkg::ST_IDLE;
            walk_node_reg    <= '0;
            symbols_left_reg <= '0;
            active_reg       <= 1'b0;
            bit_cnt_reg      <= '0;
            pend_valid_reg   <= 1'b0;
        end else begin
            state_reg        <= state_next;
            walk_node_reg    <= walk_node_next;
            symbols_left_reg <= symbols_left_next;
            active_reg       <= active_next;
            bit_cnt_reg      <= bit_cnt_next;
            pend_valid_reg   <= pend_valid_next;
        end
    end

    // Payload registers; the read index tracks the table's registered read
    always_ff @(posedge aclk) begin
        pend_sym_reg   <= pend_sym_next;
        pend_end_reg   <= pend_end_next;
        byte_reg       <= byte_next;
        root_entry_reg <= root_entry_next;
        last_idx_reg   <= rd_idx;
        oor_reg        <= !hwd_pkg::idx_in_table(rd_idx);
    end

endmodule
